>>> src/c2s_pkg.sv
`timescale 1ns / 1ps
package c2s_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int REFL_WIDTH   = 16;
  localparam int FRAC_BITS    = 24;
  localparam int CORDIC_STEPS = 31;
  localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
  localparam int ROOT_STEPS   = COORD_WIDTH;
  localparam int XY_WIDTH     = COORD_WIDTH + FRAC_BITS + 4;
  localparam int ANG_WIDTH    = 34;
  localparam int ROUND_SHIFT  = 32 - ANGLE_WIDTH;

  typedef logic [COORD_WIDTH-1:0]        mag_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic [REFL_WIDTH-1:0]         refl_t;
  typedef logic [SQ_WIDTH-1:0]           sq_t;
  typedef logic signed [XY_WIDTH-1:0]    cx_t;
  typedef logic signed [ANG_WIDTH-1:0]   ang_t;

  localparam ang_t HALF_PI = ang_t'(64'sd1 <<< 30);
  localparam ang_t PI      = ang_t'(64'sd1 <<< 31);

  typedef struct packed {
    refl_t refl;
    logic  last;
    logic  origin;
    logic  x_neg;
    logic  y_neg;
    logic  z_neg;
  } side_t;

  typedef struct packed {
    sq_t n;
    sq_t r;
  } rstep_t;

  typedef struct packed {
    cx_t  px;
    cx_t  py;
    ang_t ang;
  } cstep_t;

  // atan(2^-i) in units of pi/2^31
  function automatic ang_t atan_unit(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return ang_t'({1'b0, v});
  endfunction

  // one digit of the bitwise square root
  function automatic rstep_t root_step(input sq_t n, input sq_t r, input sq_t b);
    rstep_t o;
    if (n >= r + b) begin
      o.n = n - (r + b);
      o.r = (r >> 1) + b;
    end else begin
      o.n = n;
      o.r = r >> 1;
    end
    return o;
  endfunction

  // one CORDIC vectoring rotation, shift i is constant per stage
  function automatic cstep_t cordic_step(input cstep_t c, input int unsigned i);
    cstep_t o;
    cx_t dx;
    cx_t dy;
    dx = c.py >>> i;
    dy = c.px >>> i;
    if (!c.py[XY_WIDTH-1]) begin
      o.px  = c.px + dx;
      o.py  = c.py - dy;
      o.ang = c.ang + atan_unit(i);
    end else begin
      o.px  = c.px - dx;
      o.py  = c.py + dy;
      o.ang = c.ang - atan_unit(i);
    end
    return o;
  endfunction

  function automatic angle_t to_angle(input ang_t u);
    ang_t r;
    r = (u + ang_t'(64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > ang_t'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 1)) begin
      r = ang_t'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 1);
    end else if (r < -ang_t'(64'sd1 <<< (ANGLE_WIDTH - 1))) begin
      r = -ang_t'(64'sd1 <<< (ANGLE_WIDTH - 1));
    end
    return r[ANGLE_WIDTH-1:0];
  endfunction

endpackage

>>> src/c2s_if.sv
`timescale 1ns / 1ps
interface c2s_in_if;
  import c2s_pkg::*;
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  refl_t  reflectance_in;
  logic   last_point;
  modport source (output valid, coord_x, coord_y, coord_z, reflectance_in, last_point,
                  input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, reflectance_in, last_point,
                output ready);
endinterface

interface c2s_out_if;
  import c2s_pkg::*;
  logic   valid;
  logic   ready;
  angle_t azimuth;
  angle_t elevation;
  mag_t   distance;
  refl_t  reflectance_out;
  logic   zero_range;
  logic   last_out;
  modport source (output valid, azimuth, elevation, distance, reflectance_out, zero_range,
                  last_out, input ready);
  modport sink (input valid, azimuth, elevation, distance, reflectance_out, zero_range,
                last_out, output ready);
endinterface

>>> src/cartesian_to_spherical_point_top.sv
// Stages from input accept to result valid: abs, square, sum,
//   24 square-root digit stages, CORDIC setup, 31 CORDIC stages, angle fixup, round.
// Throughput: one item per cycle; the pipeline advances as a whole
//   whenever the output register is empty or being taken.
// Reset: asynchronous, active low, clears all stage valid bits only.
`timescale 1ns / 1ps
module cartesian_to_spherical_point_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  c2s_in_if.sink     in_i,
  c2s_out_if.source  out_o
);
  import c2s_pkg::*;

  typedef struct packed {
    side_t side;
    mag_t  ax;
    mag_t  ay;
    mag_t  az;
  } abs_t;

  typedef struct packed {
    side_t side;
    mag_t  ax;
    mag_t  ay;
    mag_t  az;
    sq_t   ax2;
    sq_t   ay2;
    sq_t   az2;
  } sqr_t;

  typedef struct packed {
    side_t side;
    mag_t  ax;
    mag_t  ay;
    mag_t  az;
    sq_t   dn;
    sq_t   dr;
    sq_t   hn;
    sq_t   hr;
  } root_t;

  typedef struct packed {
    side_t  side;
    mag_t   radius;
    logic   az_b0;
    logic   az_a0;
    logic   el_b0;
    logic   el_a0;
    cstep_t ca;
    cstep_t ce;
  } cord_t;

  typedef struct packed {
    side_t side;
    mag_t  radius;
    ang_t  azi;
    ang_t  ele;
  } fin_t;

  typedef struct packed {
    angle_t azi;
    angle_t ele;
    mag_t   radius;
    refl_t  refl;
    logic   zero;
    logic   last;
  } res_t;

  logic  en;
  logic  abs_v_q, sqr_v_q, fin_v_q, out_v_q;
  abs_t  abs_q;
  sqr_t  sqr_q;
  fin_t  fin_q;
  res_t  out_q;
  logic  root_v_q [ROOT_STEPS+1];
  root_t root_q   [ROOT_STEPS+1];
  logic  cord_v_q [CORDIC_STEPS+1];
  cord_t cord_q   [CORDIC_STEPS+1];

  abs_t  abs_d;
  root_t root0_d;
  cord_t cord0_d;
  fin_t  fin_d;
  res_t  out_d;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    abs_d.side.refl   = in_i.reflectance_in;
    abs_d.side.last   = in_i.last_point;
    abs_d.side.origin = (in_i.coord_x == '0) && (in_i.coord_y == '0) && (in_i.coord_z == '0);
    abs_d.side.x_neg  = in_i.coord_x[COORD_WIDTH-1];
    abs_d.side.y_neg  = in_i.coord_y[COORD_WIDTH-1];
    abs_d.side.z_neg  = in_i.coord_z[COORD_WIDTH-1];
    abs_d.ax = in_i.coord_x[COORD_WIDTH-1] ? mag_t'(-in_i.coord_x) : mag_t'(in_i.coord_x);
    abs_d.ay = in_i.coord_y[COORD_WIDTH-1] ? mag_t'(-in_i.coord_y) : mag_t'(in_i.coord_y);
    abs_d.az = in_i.coord_z[COORD_WIDTH-1] ? mag_t'(-in_i.coord_z) : mag_t'(in_i.coord_z);
  end

  always_comb begin
    root0_d.side = sqr_q.side;
    root0_d.ax   = sqr_q.ax;
    root0_d.ay   = sqr_q.ay;
    root0_d.az   = sqr_q.az;
    root0_d.hn   = sqr_q.ax2 + sqr_q.az2;
    root0_d.dn   = sqr_q.ax2 + sqr_q.az2 + sqr_q.ay2;
    root0_d.dr   = '0;
    root0_d.hr   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_v_q     <= 1'b0;
      sqr_v_q     <= 1'b0;
      root_v_q[0] <= 1'b0;
    end else if (en) begin
      abs_v_q     <= in_i.valid;
      sqr_v_q     <= abs_v_q;
      root_v_q[0] <= sqr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      abs_q     <= abs_d;
      sqr_q.side <= abs_q.side;
      sqr_q.ax  <= abs_q.ax;
      sqr_q.ay  <= abs_q.ay;
      sqr_q.az  <= abs_q.az;
      sqr_q.ax2 <= abs_q.ax * abs_q.ax;
      sqr_q.ay2 <= abs_q.ay * abs_q.ay;
      sqr_q.az2 <= abs_q.az * abs_q.az;
      root_q[0] <= root0_d;
    end
  end

  // square roots of both sums, one result bit per stage
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam sq_t Bit = sq_t'(1) << (SQ_WIDTH - 2 - 2 * k);
    root_t  nxt;
    rstep_t sd;
    rstep_t sh;

    always_comb begin
      sd = root_step(root_q[k].dn, root_q[k].dr, Bit);
      sh = root_step(root_q[k].hn, root_q[k].hr, Bit);
      nxt    = root_q[k];
      nxt.dn = sd.n;
      nxt.dr = sd.r;
      nxt.hn = sh.n;
      nxt.hr = sh.r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        root_v_q[k+1] <= 1'b0;
      end else if (en) begin
        root_v_q[k+1] <= root_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        root_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    mag_t horiz;
    horiz = root_q[ROOT_STEPS].hr[COORD_WIDTH-1:0];
    cord0_d.side   = root_q[ROOT_STEPS].side;
    cord0_d.radius = root_q[ROOT_STEPS].dr[COORD_WIDTH-1:0];
    cord0_d.az_b0  = (root_q[ROOT_STEPS].az == '0);
    cord0_d.az_a0  = (root_q[ROOT_STEPS].ax == '0);
    cord0_d.el_b0  = (root_q[ROOT_STEPS].ay == '0);
    cord0_d.el_a0  = (horiz == '0);
    cord0_d.ca.px  = cx_t'(root_q[ROOT_STEPS].ax) <<< FRAC_BITS;
    cord0_d.ca.py  = cx_t'(root_q[ROOT_STEPS].az) <<< FRAC_BITS;
    cord0_d.ca.ang = '0;
    cord0_d.ce.px  = cx_t'(horiz) <<< FRAC_BITS;
    cord0_d.ce.py  = cx_t'(root_q[ROOT_STEPS].ay) <<< FRAC_BITS;
    cord0_d.ce.ang = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cord_v_q[0] <= 1'b0;
    end else if (en) begin
      cord_v_q[0] <= root_v_q[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cord_q[0] <= cord0_d;
    end
  end

  // azimuth and elevation rotate side by side
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cord_t nxt;

    always_comb begin
      nxt    = cord_q[i];
      nxt.ca = cordic_step(cord_q[i].ca, i);
      nxt.ce = cordic_step(cord_q[i].ce, i);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cord_v_q[i+1] <= 1'b0;
      end else if (en) begin
        cord_v_q[i+1] <= cord_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cord_q[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    cord_t c;
    ang_t  ba;
    ang_t  be;
    c = cord_q[CORDIC_STEPS];
    // axis cases take the exact base angle
    if (c.az_b0) begin
      ba = '0;
    end else if (c.az_a0) begin
      ba = HALF_PI;
    end else begin
      ba = c.ca.ang;
    end
    if (c.el_b0) begin
      be = '0;
    end else if (c.el_a0) begin
      be = HALF_PI;
    end else begin
      be = c.ce.ang;
    end
    fin_d.side   = c.side;
    fin_d.radius = c.radius;
    if (!c.side.x_neg) begin
      fin_d.azi = c.side.z_neg ? -ba : ba;
    end else begin
      fin_d.azi = c.side.z_neg ? (ba - PI) : (PI - ba);
    end
    fin_d.ele = c.side.y_neg ? -be : be;
  end

  always_comb begin
    out_d.azi    = fin_q.side.origin ? '0 : to_angle(fin_q.azi);
    out_d.ele    = fin_q.side.origin ? '0 : to_angle(fin_q.ele);
    out_d.radius = fin_q.radius;
    out_d.refl   = fin_q.side.refl;
    out_d.zero   = fin_q.side.origin;
    out_d.last   = fin_q.side.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= cord_v_q[CORDIC_STEPS];
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.azimuth         = out_q.azi;
  assign out_o.elevation       = out_q.ele;
  assign out_o.distance        = out_q.radius;
  assign out_o.reflectance_out = out_q.refl;
  assign out_o.zero_range      = out_q.zero;
  assign out_o.last_out        = out_q.last;

endmodule
